// ===== rtl/mlr_pkg.sv =====
// Shared definitions for the midpoint line rasterizer.
// Holds the item opcodes and the step direction flags; no dependencies.
`default_nettype none

package mlr_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Direction and axis of a line, as worked out when the line is started.
	typedef struct packed {
		logic ymaj;
		logic yneg;
		logic xneg;
	} step_flags_t;

	localparam int FLAGS_W = $bits(step_flags_t);

	// Depth of the queue between the classifier and the stepper, as a log2.
	localparam int QUEUE_AW = 2;

endpackage

`default_nettype wire

// ===== rtl/mlr_front.sv =====
// Front end of the midpoint line rasterizer: accepts items and classifies
// start items into deltas, directions and the initial decision term.
// Depends on mlr_pkg.
`default_nettype none

module mlr_front
	import mlr_pkg::*;
#(
	parameter int CW = 12,
	localparam int DW = CW + 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_op,
	input  wire logic [CW-1:0] in_x0,
	input  wire logic [CW-1:0] in_y0,
	input  wire logic [CW-1:0] in_x1,
	input  wire logic [CW-1:0] in_y1,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               op_s1,
	output logic [CW-1:0]      x0_s1,
	output logic [CW-1:0]      y0_s1,
	output step_flags_t        flags_s1,
	output logic [CW-1:0]      dmaj_s1,
	output logic [CW-1:0]      dmin_s1,
	output logic [DW-1:0]      dec_s1
);

	logic              valid_s1;
	logic [CW-1:0]     dx, dy, dmaj, dmin;
	step_flags_t       flags;
	logic signed [DW-1:0] dec_init;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_comb begin
		flags.xneg = in_x1 < in_x0;
		flags.yneg = in_y1 < in_y0;
		dx = flags.xneg ? (in_x0 - in_x1) : (in_x1 - in_x0);
		dy = flags.yneg ? (in_y0 - in_y1) : (in_y1 - in_y0);
		flags.ymaj = dx < dy;
		dmaj = flags.ymaj ? dy : dx;
		dmin = flags.ymaj ? dx : dy;
		dec_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= in_op;
			x0_s1    <= in_x0;
			y0_s1    <= in_y0;
			flags_s1 <= flags;
			dmaj_s1  <= dmaj;
			dmin_s1  <= dmin;
			dec_s1   <= dec_init;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mlr_queue.sv =====
// Short first-in first-out queue, classifier to stepper; uses mlr_pkg.
// Register based; one push per cycle unless full, one pop unless empty.
`default_nettype none

module mlr_queue
	import mlr_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int DEPTH = 1 << QUEUE_AW;

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [QUEUE_AW:0] wr_ptr_q, rd_ptr_q;
	logic              full, empty, do_push, do_pop;

	assign empty = wr_ptr_q == rd_ptr_q;
	assign full  = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
		(wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = mem_q[rd_ptr_q[QUEUE_AW-1:0]];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop_ready && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mlr_back.sv =====
// Back end of the midpoint line rasterizer: holds the line in progress,
// steps it one pixel per request and drives the pixel output register.
// Depends on mlr_pkg.
`default_nettype none

module mlr_back
	import mlr_pkg::*;
#(
	parameter int CW = 12,
	localparam int DW = CW + 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_op,
	input  wire logic [CW-1:0] in_x0,
	input  wire logic [CW-1:0] in_y0,
	input  wire step_flags_t   in_flags,
	input  wire logic [CW-1:0] in_dmaj,
	input  wire logic [CW-1:0] in_dmin,
	input  wire logic [DW-1:0] in_dec,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [CW-1:0]      pixel_x,
	output logic [CW-1:0]      pixel_y,
	output logic               last_pixel
);

	logic [CW-1:0]        cur_x_q, cur_y_q, dmaj_q, dmin_q, steps_q;
	logic signed [DW-1:0] dec_q, dec_next;
	step_flags_t          flags_q;
	logic                 busy_q, out_valid_q, take, emit, minor_move;
	logic [CW-1:0]        x_next, y_next;

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign emit      = take && (in_op == OP_STEP) && busy_q;
	assign out_valid = out_valid_q;

	// The minor coordinate moves when the line passes beyond the midpoint.
	always_comb begin
		minor_move = dec_q > 0;
		dec_next = dec_q + $signed({2'b00, dmin_q, 1'b0});
		if (minor_move) begin
			dec_next = dec_next - $signed({2'b00, dmaj_q, 1'b0});
		end
		x_next = cur_x_q;
		y_next = cur_y_q;
		if (flags_q.ymaj) begin
			y_next = flags_q.yneg ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			if (minor_move) begin
				x_next = flags_q.xneg ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
			end
		end else begin
			x_next = flags_q.xneg ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
			if (minor_move) begin
				y_next = flags_q.yneg ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			dmaj_q      <= '0;
			dmin_q      <= '0;
			dec_q       <= '0;
			steps_q     <= '0;
			flags_q     <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && in_op == OP_START) begin
				cur_x_q <= in_x0;
				cur_y_q <= in_y0;
				dmaj_q  <= in_dmaj;
				dmin_q  <= in_dmin;
				dec_q   <= in_dec;
				steps_q <= in_dmaj;
				flags_q <= in_flags;
				busy_q  <= in_dmaj != '0;
			end else if (emit) begin
				cur_x_q <= x_next;
				cur_y_q <= y_next;
				dec_q   <= dec_next;
				steps_q <= steps_q - 1'b1;
				busy_q  <= steps_q != CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x    <= cur_x_q;
			pixel_y    <= cur_y_q;
			last_pixel <= steps_q == CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer: a start request loads two endpoints, each step
// request on an active line yields its next pixel, the second endpoint excluded.
// Throughput is one request per cycle unless stalled; the stepper adds, subtracts and compares.
// A step request passes these registers in order before its pixel is valid:
// the classifier register loads at the accepting edge, then the queue, then the pixel register.
// Reset clears the queue, the line state and the output valid; no line is active.
`default_nettype none

module midpoint_line_rasterizer_core
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12,
	localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// x_start, y_start, x_end, y_end from the lowest bit up, zero padded
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// op
	input  wire logic             s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// pixel_x, pixel_y from the lowest bit up, zero padded
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 3;
	localparam int QW = 1 + 4 * CW + FLAGS_W + DW;

	logic              f_valid, f_ready, f_op;
	logic [CW-1:0]     f_x0, f_y0, f_dmaj, f_dmin;
	step_flags_t       f_flags;
	logic [DW-1:0]     f_dec;
	logic [QW-1:0]     q_push, q_pop;
	logic              q_valid, q_ready;
	logic              b_op;
	logic [CW-1:0]     b_x0, b_y0, b_dmaj, b_dmin;
	step_flags_t       b_flags;
	logic [DW-1:0]     b_dec;
	logic [CW-1:0]     pix_x, pix_y;

	mlr_front #(.CW(CW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_x0     (s_axis_tdata[CW-1:0]),
		.in_y0     (s_axis_tdata[2*CW-1:CW]),
		.in_x1     (s_axis_tdata[3*CW-1:2*CW]),
		.in_y1     (s_axis_tdata[4*CW-1:3*CW]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.op_s1     (f_op),
		.x0_s1     (f_x0),
		.y0_s1     (f_y0),
		.flags_s1  (f_flags),
		.dmaj_s1   (f_dmaj),
		.dmin_s1   (f_dmin),
		.dec_s1    (f_dec)
	);

	assign q_push = {f_dec, f_dmin, f_dmaj, f_flags, f_y0, f_x0, f_op};

	mlr_queue #(.WIDTH(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_push),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_pop)
	);

	assign {b_dec, b_dmin, b_dmaj, b_flags, b_y0, b_x0, b_op} = q_pop;

	mlr_back #(.CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_op      (b_op),
		.in_x0      (b_x0),
		.in_y0      (b_y0),
		.in_flags   (b_flags),
		.in_dmaj    (b_dmaj),
		.in_dmin    (b_dmin),
		.in_dec     (b_dec),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.pixel_x    (pix_x),
		.pixel_y    (pix_y),
		.last_pixel (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({pix_y, pix_x});

endmodule

`default_nettype wire
